### rtl/core/fhpc_pkg.sv
// ----------------------------------------------------------------------------
// fhpc_pkg
// Shared constants and types for the heater drive controller.
// ----------------------------------------------------------------------------
package fhpc_pkg;

    localparam int TABLE_DEPTH  = 8;
    localparam int SETTLE_TICKS = 140;

    localparam logic ACT_INIT = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic [1:0] REG_TABLE    = 2'd0;
    localparam logic [1:0] REG_ENTRIES  = 2'd1;
    localparam logic [1:0] REG_SETPOINT = 2'd2;

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_BOOST  = 3'd1;
    localparam logic [2:0] MODE_CUT    = 3'd2;
    localparam logic [2:0] MODE_SETTLE = 3'd4;

    // fuzzy set edges and outputs
    function automatic logic signed [7:0] set_edge(input logic [3:0] i);
        case (i)
            4'd0: set_edge = -8'sd80;
            4'd1: set_edge = -8'sd30;
            4'd2: set_edge = -8'sd15;
            4'd3: set_edge = -8'sd5;
            4'd4: set_edge = 8'sd0;
            4'd5: set_edge = 8'sd5;
            4'd6: set_edge = 8'sd15;
            4'd7: set_edge = 8'sd30;
            default: set_edge = 8'sd80;
        endcase
    endfunction

    function automatic logic signed [7:0] set_out(input logic [2:0] i);
        case (i)
            3'd0: set_out = -8'sd75;
            3'd1: set_out = -8'sd35;
            3'd2: set_out = -8'sd9;
            3'd3: set_out = 8'sd1;
            3'd4: set_out = 8'sd10;
            3'd5: set_out = 8'sd50;
            default: set_out = 8'sd100;
        endcase
    endfunction

    typedef struct packed {
        logic              start;
        logic              sign;
        logic [15:0]       num;
        logic [15:0]       den;
    } div_req_t;

endpackage

### rtl/core/fhpc_div.sv
// ----------------------------------------------------------------------------
// fhpc_div
// Shared restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module fhpc_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  fhpc_pkg::div_req_t req,
    output logic               busy,
    output logic signed [16:0] quot
);
    logic [15:0] q_reg;
    logic [16:0] r_reg;
    logic [15:0] d_reg;
    logic [4:0]  cnt_reg;
    logic        neg_reg;
    logic [16:0] r_sh;
    logic [16:0] r_sub;

    assign r_sh  = {r_reg[15:0], q_reg[15]};
    assign r_sub = r_sh - {1'b0, d_reg};
    assign busy  = (cnt_reg != 5'd0);
    assign quot  = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 5'd0;
        end else if (req.start) begin
            q_reg   <= req.num;
            r_reg   <= 17'd0;
            d_reg   <= req.den;
            neg_reg <= req.sign;
            cnt_reg <= 5'd16;
        end else if (busy) begin
            if (!r_sub[16]) begin
                r_reg <= r_sub;
                q_reg <= {q_reg[14:0], 1'b1};
            end else begin
                r_reg <= r_sh;
                q_reg <= {q_reg[14:0], 1'b0};
            end
            cnt_reg <= cnt_reg - 5'd1;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> cnt_reg == 5'd16) else $error("div start");
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy && !req.start |=> cnt_reg == $past(cnt_reg) - 5'd1) else $error("div count");
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !r_reg[16]) else $error("div remainder");
endmodule

### rtl/core/fuzzy_heater_power_control.sv
// ----------------------------------------------------------------------------
// fuzzy_heater_power_control
// Heater drive controller: ceiling table, fuzzy accumulator, mode machine.
// ----------------------------------------------------------------------------
// An init word goes from accept straight to S_OUT; a tick word passes S_PRE,
// S_MODE, S_DUTY, S_DWAIT and S_POST. Every fifth tick adds the fuzzy pass after
// S_PRE: one divide per matched set (at most three) and a mean divide if the memberships sum to non-zero.
// One word at a time: s_tready is low from accept until the result is taken.
// Duty / 100 is a reciprocal multiply.
// aresetn (sync, low) restores table, entries, setpoint and controller state.
module fuzzy_heater_power_control (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [12:0] temp_error, [20:13] water_flow, [33:21] outlet_temp,
    // [45:34] outlet_reading, [53:46] pump_level
    input  logic [55:0] s_tdata,
    input  logic        s_tuser,    // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // power
    output logic        m_tuser,    // pump_step_down
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_PRE, S_FZ_SET, S_FZ_DIV, S_FZ_ACC, S_FZ_MEAN, S_FZ_MWAIT,
        S_MODE, S_DUTY, S_DWAIT, S_POST, S_OUT
    } state_t;

    state_t             state_reg;
    logic [63:0]        table_reg;
    logic [3:0]         entries_reg;
    logic [11:0]        setpoint_reg;
    logic [2:0]         period_reg;
    logic [7:0]         sat_reg;
    logic [7:0]         settle_reg;
    logic [2:0]         mode_reg;
    logic [7:0]         step_reg;
    logic signed [15:0] last_reg;
    logic signed [17:0] accum_reg;
    logic signed [14:0] err_reg;
    logic signed [9:0]  ceil_reg;
    logic [7:0]         flow_reg;
    logic signed [12:0] temp_reg;
    logic [7:0]         pump_reg;
    logic [2:0]         set_reg;
    logic [9:0]         total_reg;
    logic signed [17:0] wsum_reg;
    logic [6:0]         memb_reg;
    logic [1:0]         sel_reg;
    logic [7:0]         power_reg;
    logic               down_reg;
    logic signed [17:0] val_reg;

    fhpc_pkg::div_req_t div_req;
    logic               div_busy;
    logic signed [16:0] div_q;

    fhpc_div u_div (
        .aclk(aclk), .aresetn(aresetn), .req(div_req), .busy(div_busy), .quot(div_q)
    );

    logic signed [14:0] e_in;
    logic [3:0]         ent_eff;
    logic signed [9:0]  ceil_base;
    logic signed [19:0] slope_sum;
    logic signed [14:0] lo_e, mid_e, hi_e;
    logic signed [15:0] abs_e;
    logic [15:0]        duty_mag;
    logic [28:0]        duty_prod;
    logic signed [17:0] duty_q;

    always_comb begin
        e_in = {{2{s_tdata[12]}}, s_tdata[12:0]}
             + ((settle_reg != 8'(fhpc_pkg::SETTLE_TICKS)) ? 15'sd30 : 15'sd0);
        ent_eff = (entries_reg > 4'(fhpc_pkg::TABLE_DEPTH))
                ? 4'(fhpc_pkg::TABLE_DEPTH) : entries_reg;
        ceil_base = 10'sd255;
        if ({4'd0, flow_reg} < {8'd0, ent_eff}
            && (flow_reg == 8'd0 || temp_reg > 13'sd600))
            ceil_base = {2'b00, table_reg[{flow_reg[2:0], 3'b000} +: 8]};
        slope_sum = 20'(ceil_base) + 20'sd5 * (20'(err_reg) - 20'(last_reg));
        lo_e  = 15'(fhpc_pkg::set_edge({1'b0, set_reg}));
        mid_e = 15'(fhpc_pkg::set_edge({1'b0, set_reg} + 4'd1));
        hi_e  = 15'(fhpc_pkg::set_edge({1'b0, set_reg} + 4'd2));
        abs_e = err_reg[14] ? -16'(err_reg) : 16'(err_reg);
        // |accum| < 2^15, so * 5243 >> 19 is exact for / 100
        duty_mag  = accum_reg[17] ? 16'(-accum_reg) : 16'(accum_reg);
        duty_prod = 29'(duty_mag) * 29'd5243;
        duty_q    = accum_reg[17] ? -18'(duty_prod[28:19]) : 18'(duty_prod[28:19]);
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = power_reg;
    assign m_tuser  = down_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            table_reg    <= '1;
            entries_reg  <= 4'd0;
            setpoint_reg <= 12'd0;
            period_reg   <= 3'd0;
            sat_reg      <= 8'd0;
            settle_reg   <= 8'd0;
            mode_reg     <= fhpc_pkg::MODE_IDLE;
            step_reg     <= 8'd128;
            last_reg     <= 16'sd0;
            accum_reg    <= 18'sd0;
            div_req      <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    fhpc_pkg::REG_TABLE:    table_reg    <= cfg_data;
                    fhpc_pkg::REG_ENTRIES:  entries_reg  <= cfg_data[3:0];
                    fhpc_pkg::REG_SETPOINT: setpoint_reg <= cfg_data[11:0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        flow_reg <= s_tdata[20:13];
                        temp_reg <= s_tdata[33:21];
                        pump_reg <= s_tdata[53:46];
                        err_reg  <= e_in;
                        down_reg <= 1'b0;
                        if (s_tuser == fhpc_pkg::ACT_INIT) begin
                            period_reg <= 3'd0;
                            sat_reg    <= 8'd0;
                            settle_reg <= 8'd0;
                            mode_reg   <= fhpc_pkg::MODE_IDLE;
                            last_reg   <= 16'sd0;
                            power_reg  <= 8'd0;
                            if (s_tdata[45:34] > setpoint_reg) begin
                                step_reg  <= 8'd16;
                                accum_reg <= 18'sd12800;
                            end else begin
                                step_reg  <= 8'd128;
                                accum_reg <= 18'sd0;
                            end
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_PRE;
                        end
                    end
                end
                S_PRE: begin
                    ceil_reg <= (slope_sum < 20'sd0) ? 10'sd0
                              : (slope_sum > 20'sd255) ? 10'sd255 : 10'(slope_sum);
                    last_reg <= 16'(err_reg);
                    set_reg   <= 3'd0;
                    total_reg <= 10'd0;
                    wsum_reg  <= 18'sd0;
                    if (period_reg == 3'd4) begin
                        period_reg <= 3'd0;
                        state_reg  <= S_FZ_SET;
                    end else begin
                        period_reg <= period_reg + 3'd1;
                        state_reg  <= S_MODE;
                    end
                end
                S_FZ_SET: begin
                    if (err_reg < lo_e || err_reg > hi_e) begin
                        if (set_reg == 3'd6) state_reg <= S_FZ_MEAN;
                        set_reg <= set_reg + 3'd1;
                    end else begin
                        div_req.start <= 1'b1;
                        div_req.sign  <= 1'b0;
                        if (err_reg <= mid_e) begin
                            div_req.num <= 16'd100 * 16'(err_reg - lo_e);
                            div_req.den <= 16'(mid_e - lo_e);
                        end else begin
                            div_req.num <= 16'd100 * 16'(hi_e - err_reg);
                            div_req.den <= 16'(hi_e - mid_e);
                        end
                        state_reg <= S_FZ_DIV;
                    end
                end
                S_FZ_DIV: begin
                    div_req.start <= 1'b0;
                    if (!div_busy && !div_req.start) begin
                        memb_reg  <= div_q[6:0];
                        state_reg <= S_FZ_ACC;
                    end
                end
                S_FZ_ACC: begin
                    total_reg <= total_reg + 10'(memb_reg);
                    wsum_reg  <= wsum_reg + 18'($signed({1'b0, memb_reg}))
                               * 18'(fhpc_pkg::set_out(set_reg));
                    set_reg   <= set_reg + 3'd1;
                    state_reg <= (set_reg == 3'd6) ? S_FZ_MEAN : S_FZ_SET;
                end
                S_FZ_MEAN: begin
                    if (total_reg == 10'd0) begin
                        val_reg   <= 18'(err_reg);
                        sel_reg   <= 2'd0;
                        state_reg <= S_FZ_MWAIT;
                    end else begin
                        div_req.start <= 1'b1;
                        div_req.sign  <= wsum_reg[17];
                        div_req.num   <= wsum_reg[17] ? 16'(-wsum_reg) : 16'(wsum_reg);
                        div_req.den   <= {6'd0, total_reg};
                        val_reg       <= 18'sd0;
                        sel_reg       <= 2'd1;
                        state_reg     <= S_FZ_MWAIT;
                    end
                end
                S_FZ_MWAIT: begin
                    div_req.start <= 1'b0;
                    if (!div_busy && !div_req.start) begin
                        logic signed [18:0] na;
                        na = 19'(accum_reg) + ((sel_reg == 2'd1) ? 19'(div_q) : 19'(val_reg));
                        accum_reg <= (na < 19'sd0) ? 18'sd0
                                   : (na > 19'sd25500) ? 18'sd25500 : 18'(na);
                        sel_reg   <= 2'd0;
                        state_reg <= S_MODE;
                    end
                end
                S_MODE: begin
                    if (abs_e > 16'sd50) begin
                        if (err_reg > 15'sd50) begin
                            if (mode_reg != fhpc_pkg::MODE_BOOST) begin
                                mode_reg <= fhpc_pkg::MODE_BOOST;
                                if (accum_reg < 18'sd19200)
                                    accum_reg <= accum_reg + 18'd100 * 18'(step_reg);
                            end
                        end else if (mode_reg != fhpc_pkg::MODE_CUT) begin
                            mode_reg <= fhpc_pkg::MODE_CUT;
                            if (accum_reg > 18'sd9600)
                                accum_reg <= accum_reg - 18'd100 * 18'(step_reg);
                        end
                    end else begin
                        if (mode_reg == fhpc_pkg::MODE_BOOST
                            || mode_reg == fhpc_pkg::MODE_CUT) begin
                            mode_reg <= fhpc_pkg::MODE_SETTLE;
                            step_reg <= step_reg >> 1;
                        end
                        if (settle_reg != 8'(fhpc_pkg::SETTLE_TICKS))
                            settle_reg <= settle_reg + 8'd1;
                    end
                    state_reg <= S_DUTY;
                end
                S_DUTY: begin
                    val_reg   <= duty_q;
                    state_reg <= S_DWAIT;
                end
                S_DWAIT: begin
                    logic signed [17:0] v;
                    v = val_reg;
                    if (abs_e > 16'sd50) begin
                        if (err_reg > 15'sd50)
                            v = (err_reg > 15'sd150 || accum_reg > 18'sd20700)
                              ? 18'sd255 : v + 18'sd48;
                        else
                            v = (err_reg < -15'sd150 || accum_reg < 18'sd4800)
                              ? 18'sd0 : v - 18'sd48;
                    end
                    val_reg <= (v < 18'sd0) ? 18'sd0 : (v > 18'sd255) ? 18'sd255 : v;
                    state_reg <= S_POST;
                end
                S_POST: begin
                    if (val_reg == 18'sd255) begin
                        sat_reg <= sat_reg + 8'd1;
                        if (sat_reg == 8'd255 && pump_reg > 8'd2) begin
                            down_reg  <= 1'b1;
                            accum_reg <= 18'sd19200;
                            step_reg  <= 8'd32;
                        end
                    end else if (sat_reg != 8'd0) begin
                        sat_reg <= sat_reg - 8'd1;
                    end
                    power_reg <= (val_reg < 18'(ceil_reg)) ? val_reg[7:0] : ceil_reg[7:0];
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (m_tready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid) else $error("ready while result pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result hold");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> period_reg <= 3'd4) else $error("period range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> sat_reg == 8'd0 && step_reg == 8'd32)
        else $error("step down");
endmodule

### tb/tb_fuzzy_heater_power_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fuzzy_heater_power_control
// Drives init and tick words through the heater drive controller with random
// stalls on both sides, over several table and setpoint settings. A word-level
// model of the controller predicts power and pump step-down for each word.
// ----------------------------------------------------------------------------

typedef struct {
    logic [7:0] power;
    logic       step_down;
} drive_t;

class drive_scoreboard;
    logic [63:0] ceil_table;
    logic [3:0]  entries;
    logic [11:0] setpoint;
    int          period_cnt, sat_cnt, settle_cnt, step, last_err, accum;
    logic [2:0]  mode;
    drive_t      pending_q[$];
    int          mismatches;

    function new();
        ceil_table = '1;
        entries    = 0;
        setpoint   = 0;
        mismatches = 0;
        clear();
    endfunction

    function void clear();
        period_cnt = 0;
        sat_cnt    = 0;
        settle_cnt = 0;
        mode       = fhpc_pkg::MODE_IDLE;
        step       = 128;
        last_err   = 0;
        accum      = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [63:0] val);
        case (idx)
            fhpc_pkg::REG_TABLE:    ceil_table = val;
            fhpc_pkg::REG_ENTRIES:  entries = val[3:0];
            fhpc_pkg::REG_SETPOINT: setpoint = val[11:0];
            default: ;
        endcase
    endfunction

    function void note_word(logic act, logic [55:0] d);
        int     edges[9] = '{-80, -30, -15, -5, 0, 5, 15, 30, 80};
        int     outs[7]  = '{-75, -35, -9, 1, 10, 50, 100};
        int     err, temp, flow, pump, lim, ceil_v, val, abs_err, total, wsum, m;
        drive_t r;
        r.power = 0;
        r.step_down = 0;
        if (act == fhpc_pkg::ACT_INIT) begin
            clear();
            if (d[45:34] > setpoint) begin
                step  = 16;
                accum = 12800;
            end
            pending_q.push_back(r);
            return;
        end
        err  = int'($signed(d[12:0]));
        flow = d[20:13];
        temp = int'($signed(d[33:21]));
        pump = d[53:46];
        lim  = entries > fhpc_pkg::TABLE_DEPTH ? fhpc_pkg::TABLE_DEPTH : entries;
        if (settle_cnt != fhpc_pkg::SETTLE_TICKS) err += 30;
        abs_err = err < 0 ? -err : err;
        ceil_v = 255;
        if (flow < lim && (flow == 0 || temp > 600)) ceil_v = ceil_table[8*flow +: 8];
        ceil_v += 5 * (err - last_err);
        last_err = err;
        ceil_v = ceil_v < 0 ? 0 : (ceil_v > 255 ? 255 : ceil_v);

        period_cnt = (period_cnt + 1) & 7;
        if (period_cnt >= 5) begin
            period_cnt = 0;
            total = 0;
            wsum  = 0;
            for (int i = 0; i < 7; i++) begin
                if (err < edges[i] || err > edges[i+2]) continue;
                m = err <= edges[i+1] ? (100 * (err - edges[i])) / (edges[i+1] - edges[i])
                                      : (100 * (edges[i+2] - err)) / (edges[i+2] - edges[i+1]);
                total += m;
                wsum  += m * outs[i];
            end
            accum += total != 0 ? wsum / total : err;
            accum = accum < 0 ? 0 : (accum > 25500 ? 25500 : accum);
        end

        if (abs_err > 50) begin
            if (err > 50) begin
                if (mode != fhpc_pkg::MODE_BOOST) begin
                    mode = fhpc_pkg::MODE_BOOST;
                    if (accum < 19200) accum += 100 * step;
                end
                val = (err > 150 || accum > 20700) ? 255 : accum / 100 + 48;
            end else begin
                if (mode != fhpc_pkg::MODE_CUT) begin
                    mode = fhpc_pkg::MODE_CUT;
                    if (accum > 9600) accum -= 100 * step;
                end
                val = (err < -150 || accum < 4800) ? 0 : accum / 100 - 48;
            end
        end else begin
            if (mode == fhpc_pkg::MODE_BOOST || mode == fhpc_pkg::MODE_CUT) begin
                mode = fhpc_pkg::MODE_SETTLE;
                step = step >> 1;
            end
            if (settle_cnt != fhpc_pkg::SETTLE_TICKS) settle_cnt = (settle_cnt + 1) & 255;
            val = accum / 100;
        end
        val = val < 0 ? 0 : (val > 255 ? 255 : val);

        if (val == 255) begin
            sat_cnt = (sat_cnt + 1) & 255;
            if (sat_cnt == 0 && pump > 2) begin
                r.step_down = 1;
                accum = 19200;
                step  = 32;
            end
        end else if (sat_cnt > 0) begin
            sat_cnt--;
        end
        r.power = val < ceil_v ? val : ceil_v;
        pending_q.push_back(r);
    endfunction

    function void check_word(logic [7:0] power, logic step_down);
        drive_t e;
        if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: power %0d step %0b", power, step_down);
            return;
        end
        e = pending_q.pop_front();
        if (e.power !== power || e.step_down !== step_down) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp power %0d step %0b, got power %0d step %0b",
                         e.power, e.step_down, power, step_down);
        end
    endfunction
endclass

module tb_fuzzy_heater_power_control;
    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = 0;
    logic [63:0] cfg_data = '0;

    drive_scoreboard sb = new();
    bit quiet = 0;
    int stall = 0;
    int idle_cycles = 0;

    fuzzy_heater_power_control dut (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser);
        if (stall > 0) begin
            stall--;
            m_tready <= 0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 13) - 1;
            m_tready <= 0;
        end else begin
            m_tready <= 1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles > 5000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_word(logic act, int err, int flow, int temp, int rd, int pump);
        logic [55:0] d;
        d = {2'b00, pump[7:0], rd[11:0], temp[12:0], flow[7:0], err[12:0]};
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= d;
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        sb.note_word(act, d);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
        cfg_we <= 0;
        @(posedge aclk);
    endtask

    task automatic tick(int err, int flow, int temp, int pump);
        send_word(fhpc_pkg::ACT_TICK, err, flow, temp, $urandom_range(0, 4095), pump);
    endtask

    task automatic random_run(int words);
        int center, e, n;
        n = 0;
        while (n < words) begin
            send_word(fhpc_pkg::ACT_INIT, $urandom_range(0, 8191) - 4096,
                      $urandom_range(0, 255), $urandom_range(0, 8191) - 4096,
                      $urandom_range(0, 4095), $urandom_range(0, 255));
            n++;
            center = $urandom_range(0, 3) == 0 ? $urandom_range(0, 8191) - 4096
                                               : $urandom_range(0, 400) - 200;
            e = center;
            repeat ($urandom_range(10, 80)) begin
                if ($urandom_range(0, 15) == 0) e = $urandom_range(0, 8191) - 4096;
                else e = e + $urandom_range(0, 40) - 20;
                if (e > 4095) e = 4095;
                if (e < -4096) e = -4096;
                tick(e, $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 9),
                     $urandom_range(0, 1) ? $urandom_range(0, 8191) - 4096
                                          : $urandom_range(550, 700),
                     $urandom_range(0, 255));
                n++;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed
        write_reg(fhpc_pkg::REG_TABLE, 64'h80_40_20_10_08_04_02_C8);
        write_reg(fhpc_pkg::REG_ENTRIES, 8);
        write_reg(fhpc_pkg::REG_SETPOINT, 2048);
        send_word(fhpc_pkg::ACT_INIT, 0, 0, 0, 4095, 0);
        tick(4095, 0, 0, 255);
        tick(-4096, 0, 4095, 0);
        tick(0, 3, 601, 3);
        tick(0, 3, 600, 2);
        tick(51, 7, -4096, 1);
        tick(50, 8, 700, 128);
        tick(-51, 255, 700, 255);
        tick(150, 0, 0, 3);
        tick(151, 1, 1000, 3);
        tick(-150, 2, 1000, 3);
        tick(-151, 0, 0, 3);
        send_word(fhpc_pkg::ACT_INIT, 4095, 255, 4095, 0, 255);
        tick(-30, 0, 0, 0);
        tick(-25, 0, 0, 0);
        tick(-80, 0, 0, 0);
        tick(20, 0, 0, 0);
        drain();

        // long saturation and long settle
        send_word(fhpc_pkg::ACT_INIT, 0, 0, 0, 0, 0);
        repeat (300) tick(4095, 255, 0, 255);
        send_word(fhpc_pkg::ACT_INIT, 0, 0, 0, 0, 0);
        repeat (160) tick($urandom_range(0, 60) - 60, 255, 0, 10);
        drain();

        write_reg(fhpc_pkg::REG_TABLE, 64'h0);
        write_reg(fhpc_pkg::REG_ENTRIES, 15);
        write_reg(fhpc_pkg::REG_SETPOINT, 4095);
        random_run(280);
        drain();

        write_reg(fhpc_pkg::REG_TABLE, {$urandom, $urandom});
        write_reg(fhpc_pkg::REG_ENTRIES, 5);
        write_reg(fhpc_pkg::REG_SETPOINT, 0);
        random_run(280);
        drain();

        write_reg(fhpc_pkg::REG_TABLE, '1);
        write_reg(fhpc_pkg::REG_ENTRIES, 0);
        write_reg(fhpc_pkg::REG_SETPOINT, $urandom_range(0, 4095));
        random_run(280);
        drain();

        write_reg(fhpc_pkg::REG_TABLE, {$urandom, $urandom});
        write_reg(fhpc_pkg::REG_ENTRIES, 9);
        write_reg(fhpc_pkg::REG_SETPOINT, $urandom_range(0, 4095));
        random_run(230);
        quiet = 1;
        random_run(160);
        drain();

        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
